/* hw/rtl/gad_pkg.sv */
// gad_pkg: shared widths for the Gegenbauer alpha-derivative block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package gad_pkg;

  localparam int ORDER_W = 10;
  localparam int POINT_W = 32;
  localparam int VALUE_W = 32;

  typedef logic [ORDER_W-1:0]        order_t;
  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

/* hw/rtl/gad_if.sv */
// gad_if: valid/ready channel interfaces for requests and results.
// Depends on gad_pkg for payload types.
`default_nettype none
interface gad_in_if;
  logic            valid;
  logic            ready;
  gad_pkg::order_t order;
  gad_pkg::point_t point;

  modport source (output valid, output order, output point, input ready);
  modport sink   (input valid, input order, input point, output ready);
endinterface

interface gad_out_if;
  logic            valid;
  logic            ready;
  gad_pkg::value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gad_mul.sv */
// gad_mul: shared signed multiplier with a registered product.
// No dependencies; instantiated by the top level.
`default_nettype none
module gad_mul #(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic signed [W-1:0]   op_a,
  input  wire logic signed [W-1:0]   op_b,
  output logic signed [2*W-1:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (2*W)'(op_a) * (2*W)'(op_b);
  end

endmodule
`default_nettype wire

/* hw/rtl/gad_div.sv */
// gad_div: bit-serial restoring divider, one quotient bit per cycle.
// No dependencies; instantiated by the top level.
`default_nettype none
module gad_div #(
  parameter int DW  = 42,
  parameter int DVW = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                busy,
  output logic [DW-1:0]       quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]  quo_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] d_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic [DVW:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? DVW'(rem_sh - {1'b0, d_r}) : rem_sh[DVW-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* hw/rtl/gegenbauer_alpha_derivative_at_zero_top.sv */
// Channel | dir | payload                      | handshake
// in_ch   | in  | order[9:0], point[31:0] Q1.F | valid/ready
// out_ch  | out | value[31:0] Q2.(F-1)         | valid/ready
// Orders 0 and 1 go from idle straight to S_FIN, order 2 via S_MXX and S_SQR. Larger
// orders run one step per order above 2 (S_MXB, S_MT1-S_MT4, S_DST, S_DIV), each
// waiting on the bit-serial divider (one quotient bit per cycle).
// Reset is synchronous and needs no clearing pass. A new request is taken as
// soon as the previous result sits in the output register.
// Depends on gad_pkg, gad_if, gad_mul and gad_div.
`default_nettype none
module gegenbauer_alpha_derivative_at_zero_top #(
  parameter int MAX_ORDER = 1023,
  parameter int FRAC_BITS = 30
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gad_in_if.sink     in_ch,
  gad_out_if.source  out_ch
);

  localparam int VW   = FRAC_BITS + 2;
  localparam int IW   = $clog2(MAX_ORDER + 1);
  localparam int MW   = (VW > IW + 2) ? VW : IW + 2;
  localparam int PW   = 2 * MW;
  localparam int NUMW = VW + IW + 1;
  localparam int NMW  = NUMW - 1;

  localparam logic signed [VW-1:0] ONE_V  = VW'(longint'(1) << FRAC_BITS);
  localparam logic signed [VW-1:0] HALF_V = VW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [gad_pkg::POINT_W-1:0] ONE_P =
    gad_pkg::POINT_W'(longint'(1) << FRAC_BITS);
  localparam logic [NMW-1:0]       ONE_Q  = NMW'(longint'(1) << FRAC_BITS);
  localparam logic signed [PW-1:0] RND_P  = PW'((longint'(1) << FRAC_BITS) - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MXX  = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_MXB  = 4'd3;
  localparam logic [3:0] S_MT1  = 4'd4;
  localparam logic [3:0] S_MT2  = 4'd5;
  localparam logic [3:0] S_MT3  = 4'd6;
  localparam logic [3:0] S_MT4  = 4'd7;
  localparam logic [3:0] S_DST  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic                    out_valid_r;
  gad_pkg::value_t         value_r;
  logic signed [VW-1:0]    x_r, a_r, b_r, xb_r;
  logic [IW-1:0]           n_r, i_r;
  logic signed [NUMW-1:0]  t_r, num_r;

  logic signed [VW-1:0]    x_in;
  logic [IW-1:0]           n_in;
  logic                    req_take;
  logic                    res_load;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    p_bias;
  logic signed [VW-1:0]    p_tz;
  logic [IW:0]             k1;
  logic [IW-1:0]           im2;
  logic                    div_start, div_busy;
  logic [NMW-1:0]          div_mag, div_q;
  logic signed [VW-1:0]    q_mag, c_val;

  assign req_take = in_ch.valid && in_ch.ready;
  assign res_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = value_r;

  always_comb begin
    if (in_ch.point > ONE_P) begin
      x_in = ONE_V;
    end else if (in_ch.point < -ONE_P) begin
      x_in = -ONE_V;
    end else begin
      x_in = VW'(in_ch.point);
    end
    if (32'(in_ch.order) > 32'(MAX_ORDER)) begin
      n_in = IW'(MAX_ORDER);
    end else begin
      n_in = IW'(in_ch.order);
    end
  end

  // truncate product toward zero to F-1 fraction bits of the result format
  assign p_bias = prod_r + (prod_r[PW-1] ? RND_P : PW'(0));
  assign p_tz   = VW'(p_bias >>> FRAC_BITS);

  assign k1  = {i_r - IW'(1), 1'b0};
  assign im2 = i_r - IW'(2);

  always_comb begin
    unique case (state_r)
      S_MXX: begin
        mul_a = MW'(x_r);
        mul_b = MW'(x_r);
      end
      S_MXB: begin
        mul_a = MW'(x_r);
        mul_b = MW'(b_r);
      end
      S_MT2: begin
        mul_a = MW'(k1);
        mul_b = MW'(xb_r);
      end
      S_MT3: begin
        mul_a = MW'(im2);
        mul_b = MW'(a_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gad_mul #(.W(MW)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign div_start = (state_r == S_DST);
  assign div_mag   = num_r[NUMW-1] ? NMW'(-num_r) : NMW'(num_r);

  gad_div #(.DW(NMW), .DVW(IW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (i_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign q_mag = (div_q > ONE_Q) ? ONE_V : VW'(div_q);
  assign c_val = num_r[NUMW-1] ? -q_mag : q_mag;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_take) begin
          state_nxt = (n_in < IW'(2)) ? S_FIN : S_MXX;
        end
      end
      S_MXX: state_nxt = S_SQR;
      S_SQR: state_nxt = (n_r == IW'(2)) ? S_FIN : S_MXB;
      S_MXB: state_nxt = S_MT1;
      S_MT1: state_nxt = S_MT2;
      S_MT2: state_nxt = S_MT3;
      S_MT3: state_nxt = S_MT4;
      S_MT4: state_nxt = S_DST;
      S_DST: state_nxt = S_DIV;
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = (i_r == n_r) ? S_FIN : S_MXB;
        end
      end
      S_FIN: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_r <= gad_pkg::VALUE_W'(b_r);
    end
    case (state_r)
      S_IDLE: begin
        if (req_take) begin
          x_r <= x_in;
          n_r <= n_in;
          if (n_in == IW'(0)) begin
            b_r <= '0;
          end else begin
            b_r <= x_in;
          end
        end
      end
      S_SQR: begin
        a_r <= x_r;
        b_r <= p_tz - HALF_V;
        i_r <= IW'(3);
      end
      S_MT1: xb_r <= p_tz;
      S_MT3: t_r <= NUMW'(prod_r);
      S_MT4: num_r <= t_r - NUMW'(prod_r);
      S_DIV: begin
        if (!div_busy) begin
          a_r <= b_r;
          b_r <= c_val;
          if (i_r != n_r) begin
            i_r <= i_r + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.value <= ONE_P) && (out_ch.value >= -ONE_P))
    else $error("result outside [-2,2]");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> !div_busy)
    else $error("divider busy outside divide phase");

  a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MXB) |-> (i_r >= IW'(3)) && (i_r <= n_r))
    else $error("step index out of range");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && !out_ch.ready |=> (state_r == S_FIN))
    else $error("result dropped while output full");
`endif

endmodule
`default_nettype wire

/* sim/gad_value_checker.sv */
// gad_value_checker: watches the request and result channels, predicts each value
// with a fixed-point model of the alpha-derivative recurrence and compares in order.
// Depends on gad_pkg and the channel interfaces in gad_if.
`default_nettype none
module gad_value_checker #(
  parameter int MAX_ORDER = 1023,
  parameter int FRAC_BITS = 30
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gad_in_if         in_ch,
  gad_out_if        out_ch,
  output int        mismatches,
  output int        outstanding,
  output int        values_checked
);
  import gad_pkg::*;

  localparam longint UNIT_X   = 64'sd1 << FRAC_BITS;
  localparam longint UNIT_RES = 64'sd1 << (FRAC_BITS - 1);
  localparam longint SAT_LIM  = 64'sd1 << FRAC_BITS;
  localparam int     REPORT_MAX = 10;

  value_t expected_values[$];

  function automatic longint shift_toward_zero(longint v, int s);
    if (v < 0) begin
      return -((-v) >>> s);
    end
    return v >>> s;
  endfunction

  function automatic longint clamp_two(longint v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic value_t alpha_derivative(order_t ord, point_t pt);
    longint x;
    longint a;
    longint b;
    longint c;
    longint xb;
    longint num;
    int n;
    x = pt;
    if (x > UNIT_X) x = UNIT_X;
    if (x < -UNIT_X) x = -UNIT_X;
    n = ord;
    if (n > MAX_ORDER) n = MAX_ORDER;
    if (n == 0) return '0;
    a = x;
    if (n == 1) return value_t'(clamp_two(a));
    b = clamp_two(shift_toward_zero(x * x, FRAC_BITS) - UNIT_RES);
    if (n == 2) return value_t'(b);
    c = b;
    for (int i = 3; i <= n; i++) begin
      xb  = shift_toward_zero(x * b, FRAC_BITS);
      num = longint'(2 * (i - 1)) * xb - longint'(i - 2) * a;
      c   = clamp_two(num / longint'(i));
      a   = b;
      b   = c;
    end
    return value_t'(c);
  endfunction

  always @(posedge clk) begin
    value_t want;
    if (!rst_n) begin
      mismatches     <= 0;
      outstanding    <= 0;
      values_checked <= 0;
      expected_values.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected result 0x%08h with no request pending", out_ch.value);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = expected_values.pop_front();
          if (out_ch.value !== want) begin
            if (mismatches < REPORT_MAX) begin
              $display("value mismatch on result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                       values_checked, want, want, out_ch.value, out_ch.value);
            end
            mismatches <= mismatches + 1;
          end
        end
        values_checked <= values_checked + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_values.push_back(alpha_derivative(in_ch.order, in_ch.point));
      end
      outstanding <= expected_values.size();
    end
  end
endmodule
`default_nettype wire

/* sim/gegenbauer_alpha_derivative_at_zero_top_test.sv */
// gegenbauer_alpha_derivative_at_zero_top_test: clock, reset and request stimulus
// for the alpha-derivative block; checking is done by gad_value_checker.
// Depends on gad_pkg, gad_if, the block's top level and gad_value_checker.
`default_nettype none
module gegenbauer_alpha_derivative_at_zero_top_test;
  import gad_pkg::*;

  localparam int     CYCLE_LIMIT  = 20_000_000;
  localparam int     RANDOM_COUNT = 80;
  localparam int     DRAIN_CYCLES = 64;
  localparam longint UNIT_X       = 64'sd1 << 30;

  logic clk;
  logic rst_n;
  bit   stall_enable;
  int   cycle_count;
  int   sent_count;
  int   directed_count;
  int   clamped_count;
  int   top_order;
  int   mismatches;
  int   outstanding;
  int   values_checked;

  gad_in_if  in_ch ();
  gad_out_if out_ch ();

  gegenbauer_alpha_derivative_at_zero_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gad_value_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .values_checked (values_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !stall_enable || ($urandom_range(99) >= 34);
  end

  task automatic send_request(input order_t ord, input point_t pt);
    while (stall_enable && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.order <= ord;
    in_ch.point <= pt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    if (longint'(pt) > UNIT_X || longint'(pt) < -UNIT_X) clamped_count++;
    if (int'(ord) > top_order) top_order = ord;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic order_t pick_order();
    int r;
    r = $urandom_range(99);
    if (r < 80) return order_t'($urandom_range(40));
    if (r < 95) return order_t'($urandom_range(200, 41));
    if (r < 98) return order_t'($urandom_range(1022, 201));
    return order_t'(1023);
  endfunction

  function automatic point_t pick_point();
    int r;
    r = $urandom_range(99);
    if (r < 75) return point_t'(longint'($urandom_range(32'h8000_0000, 0)) - UNIT_X);
    if (r < 80) return point_t'(UNIT_X);
    if (r < 85) return point_t'(-UNIT_X);
    return point_t'($urandom);
  endfunction

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    stall_enable = 1'b1;
    cycle_count  = 0;
    in_ch.valid  = 1'b0;
    in_ch.order  = '0;
    in_ch.point  = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // orders 0..2 special cases, sample higher orders, clamping of x, saturation at +-2, largest order
    send_request(order_t'(0), point_t'(0));
    send_request(order_t'(0), point_t'(UNIT_X));
    send_request(order_t'(1), point_t'(UNIT_X));
    send_request(order_t'(1), point_t'(-UNIT_X));
    send_request(order_t'(1), point_t'(32'h7FFF_FFFF));
    send_request(order_t'(1), point_t'(32'h8000_0000));
    send_request(order_t'(1), point_t'(32'h2000_0000));
    send_request(order_t'(2), point_t'(UNIT_X));
    send_request(order_t'(2), point_t'(0));
    send_request(order_t'(2), point_t'(-UNIT_X));
    send_request(order_t'(2), point_t'(32'h4000_0001));
    send_request(order_t'(3), point_t'(32'h2000_0000));
    send_request(order_t'(3), point_t'(-UNIT_X));
    send_request(order_t'(4), point_t'(UNIT_X));
    send_request(order_t'(5), point_t'(32'hC000_0001));
    send_request(order_t'(7), point_t'(32'h1333_3333));
    send_request(order_t'(16), point_t'(32'hD333_3333));
    send_request(order_t'(33), point_t'(32'h0000_0001));
    send_request(order_t'(512), point_t'(32'h3FFF_FFFF));
    send_request(order_t'(1023), point_t'(32'hF0F0_F0F1));
    directed_count = sent_count;

    drain_results();

    for (int k = 0; k < RANDOM_COUNT; k++) begin
      stall_enable <= !(k >= 35 && k < 60);
      send_request(pick_order(), pick_point());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed), orders up to %0d, %0d points clamped",
             sent_count, directed_count, top_order, clamped_count);
    $display("%0d results checked in %0d cycles, %0d mismatches",
             values_checked, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
